// ===== rtl/dchd_pkg.sv =====
// dchd_pkg: shared types and constants of the chunk header deframer
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
package dchd_pkg;

  // configuration port
  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned RegIdxWidth = 1;
  localparam logic [RegIdxWidth-1:0] RegStartTick = 1'b0;

  // field widths
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned TickWidth = 32;
  localparam int unsigned SizeWidth = 16;
  localparam int unsigned ExtraWidth = 3;

  // lead byte layout
  localparam int unsigned MarkerBit = 7;
  localparam int unsigned KeyframeBit = 6;
  localparam int unsigned DeltaWidth = 6;
  localparam int unsigned CodeWidth = 5;
  localparam logic [CodeWidth-1:0] SizeCodeByte = 5'd30;
  localparam logic [CodeWidth-1:0] SizeCodeWord = 5'd31;

  // extra header bytes
  localparam logic [ExtraWidth-1:0] ExtraTick = 3'd4;
  localparam logic [ExtraWidth-1:0] ExtraSizeByte = 3'd1;
  localparam logic [ExtraWidth-1:0] ExtraSizeWord = 3'd2;

  typedef enum logic [1:0] {
    PhaseIdle    = 2'd0,
    PhaseTick    = 2'd1,
    PhaseSize    = 2'd2,
    PhasePayload = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindTick    = 2'd0,
    KindHeader  = 2'd1,
    KindPayload = 2'd2,
    KindTrunc   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 stream_end;
  } item_t;

  typedef struct packed {
    kind_e                kind;
    logic [1:0]           chunk_type;
    logic                 keyframe;
    logic [TickWidth-1:0] tick;
    logic [SizeWidth-1:0] payload_size;
    logic [ByteWidth-1:0] payload_byte;
    logic                 payload_last;
    logic                 truncated;
  } result_t;

endpackage

// ===== rtl/dchd_item_if.sv =====
// dchd_item_if: input byte channel (valid/ready plus byte and end flag)
// depends on dchd_pkg
`timescale 1ns / 1ps
interface dchd_item_if
  import dchd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] data_byte;
  logic                 stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

// ===== rtl/dchd_result_if.sv =====
// dchd_result_if: result channel (valid/ready plus header or payload fields)
// depends on dchd_pkg
`timescale 1ns / 1ps
interface dchd_result_if
  import dchd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [1:0]           chunk_type;
  logic                 keyframe;
  logic [TickWidth-1:0] tick;
  logic [SizeWidth-1:0] payload_size;
  logic [ByteWidth-1:0] payload_byte;
  logic                 payload_last;
  logic                 truncated;

  modport source (
    output valid, output kind, output chunk_type, output keyframe, output tick,
    output payload_size, output payload_byte, output payload_last, output truncated,
    input ready
  );
  modport sink (
    input valid, input kind, input chunk_type, input keyframe, input tick,
    input payload_size, input payload_byte, input payload_last, input truncated,
    output ready
  );
endinterface

// ===== rtl/demo_chunk_header_deframer.sv =====
// demo_chunk_header_deframer: byte-wise parser of a recorded tick/chunk stream
// path: a byte goes through the input reg, the single parse step, then the result reg
// throughput: one byte per cycle unless result_o.ready holds the result register
// reset: rst_ni clears all control state; the running tick and start tick return to zero
// depends on dchd_pkg, dchd_item_if, dchd_result_if
`timescale 1ns / 1ps
module demo_chunk_header_deframer
  import dchd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // channels
  dchd_item_if.sink             item_i,
  dchd_result_if.source         result_o
);

  // configuration register
  logic [RegIdxWidth-1:0] reg_idx;
  logic                   cfg_wr;
  logic [TickWidth-1:0]   start_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrWidth-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == RegStartTick);
  assign prdata  = (reg_idx == RegStartTick) ? start_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_wr) begin
      start_q <= pwdata;
    end
  end

  // input register
  logic  s1_vld_q;
  item_t s1_q;
  logic  s1_adv;
  logic  in_acc;
  logic  out_vld_q;

  assign s1_adv       = s1_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !s1_vld_q || s1_adv;
  assign in_acc       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= '{data_byte: item_i.data_byte, stream_end: item_i.stream_end};
    end
  end

  // parser state
  phase_e                phase_q, phase_d;
  logic [ExtraWidth-1:0] extra_q, extra_d;
  logic [TickWidth-1:0]  gather_q, gather_d;
  logic [TickWidth-1:0]  tick_q, tick_d, tick_upd;
  logic [ByteWidth-1:0]  lead_q, lead_d;
  logic [SizeWidth-1:0]  left_q, left_d;

  // shared decode of the current byte
  logic [ByteWidth-1:0]  b;
  logic                  is_end;
  logic [DeltaWidth-1:0] delta;
  logic [CodeWidth-1:0]  code;
  logic [ExtraWidth-1:0] extra_dec;
  logic [TickWidth-1:0]  tick_gather;
  logic [SizeWidth-1:0]  size_gather;
  logic                  pay_last;

  assign b           = s1_q.data_byte;
  assign is_end      = s1_q.stream_end;
  assign delta       = b[DeltaWidth-1:0];
  assign code        = b[CodeWidth-1:0];
  assign extra_dec   = extra_q - 3'd1;
  assign tick_gather = {gather_q[TickWidth-ByteWidth-1:0], b};
  assign size_gather = ((lead_q[CodeWidth-1:0] == SizeCodeWord) && (extra_q == 3'd1))
                       ? {b, gather_q[ByteWidth-1:0]} : {{(SizeWidth-ByteWidth){1'b0}}, b};
  assign pay_last    = (left_q <= 16'd1);

  // next state
  always_comb begin
    logic             hdr;
    logic [SizeWidth-1:0] hdr_size;
    hdr      = 1'b0;
    hdr_size = '0;
    phase_d  = phase_q;
    extra_d  = extra_q;
    gather_d = gather_q;
    tick_upd = tick_q;
    lead_d   = lead_q;
    left_d   = left_q;
    case (phase_q)
      PhaseIdle: begin
        lead_d = b;
        if (b[MarkerBit]) begin
          if (delta != '0) begin
            tick_upd = tick_q + {{(TickWidth-DeltaWidth){1'b0}}, delta};
          end else if (!is_end) begin
            phase_d  = PhaseTick;
            extra_d  = ExtraTick;
            gather_d = '0;
          end
        end else if (code < SizeCodeByte) begin
          hdr      = 1'b1;
          hdr_size = {{(SizeWidth-CodeWidth){1'b0}}, code};
        end else if (!is_end) begin
          phase_d  = PhaseSize;
          extra_d  = (code == SizeCodeWord) ? ExtraSizeWord : ExtraSizeByte;
          gather_d = '0;
        end
      end
      PhaseTick: begin
        gather_d = tick_gather;
        extra_d  = extra_dec;
        if (extra_dec == '0) begin
          tick_upd = tick_gather;
          phase_d  = PhaseIdle;
          extra_d  = '0;
          gather_d = '0;
          left_d   = '0;
        end
      end
      PhaseSize: begin
        gather_d = {{(TickWidth-SizeWidth){1'b0}}, size_gather};
        extra_d  = extra_dec;
        if (extra_dec == '0) begin
          hdr      = 1'b1;
          hdr_size = size_gather;
        end
      end
      PhasePayload: begin
        left_d = left_q - 16'd1;
        if (pay_last) begin
          phase_d  = PhaseIdle;
          extra_d  = '0;
          gather_d = '0;
          left_d   = '0;
        end
      end
      default: begin
        phase_d = PhaseIdle;
      end
    endcase
    // a data header ends the header phase
    if (hdr) begin
      phase_d  = PhaseIdle;
      extra_d  = '0;
      gather_d = '0;
      left_d   = '0;
      if (!is_end && (hdr_size != '0)) begin
        phase_d = PhasePayload;
        left_d  = hdr_size;
      end
    end
    // end of stream returns to idle and reloads the tick
    tick_d = tick_upd;
    if (is_end) begin
      phase_d  = PhaseIdle;
      extra_d  = '0;
      gather_d = '0;
      left_d   = '0;
      tick_d   = start_q;
    end
  end

  // result fields
  result_t res;
  logic    res_vld;

  always_comb begin
    res          = '0;
    res.kind     = KindTick;
    res.tick     = tick_upd;
    res_vld      = 1'b0;
    case (phase_q)
      PhaseIdle: begin
        if (b[MarkerBit]) begin
          if (delta != '0) begin
            res_vld      = 1'b1;
            res.keyframe = b[KeyframeBit];
          end else if (is_end) begin
            res_vld       = 1'b1;
            res.kind      = KindTrunc;
            res.truncated = 1'b1;
          end
        end else if (code < SizeCodeByte) begin
          res_vld          = 1'b1;
          res.kind         = KindHeader;
          res.chunk_type   = b[6:5];
          res.payload_size = {{(SizeWidth-CodeWidth){1'b0}}, code};
          res.truncated    = is_end && (code != '0);
        end else if (is_end) begin
          res_vld       = 1'b1;
          res.kind      = KindTrunc;
          res.truncated = 1'b1;
        end
      end
      PhaseTick: begin
        if (extra_dec == '0) begin
          res_vld      = 1'b1;
          res.keyframe = lead_q[KeyframeBit];
        end else if (is_end) begin
          res_vld       = 1'b1;
          res.kind      = KindTrunc;
          res.truncated = 1'b1;
        end
      end
      PhaseSize: begin
        if (extra_dec == '0) begin
          res_vld          = 1'b1;
          res.kind         = KindHeader;
          res.chunk_type   = lead_q[6:5];
          res.payload_size = size_gather;
          res.truncated    = is_end && (size_gather != '0);
        end else if (is_end) begin
          res_vld       = 1'b1;
          res.kind      = KindTrunc;
          res.truncated = 1'b1;
        end
      end
      PhasePayload: begin
        res_vld          = 1'b1;
        res.kind         = KindPayload;
        res.chunk_type   = lead_q[6:5];
        res.payload_byte = b;
        res.payload_last = pay_last || is_end;
        res.truncated    = is_end && !pay_last;
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhaseIdle;
      extra_q  <= '0;
      gather_q <= '0;
      tick_q   <= '0;
      lead_q   <= '0;
      left_q   <= '0;
    end else begin
      if (s1_adv) begin
        phase_q  <= phase_d;
        extra_q  <= extra_d;
        gather_q <= gather_d;
        lead_q   <= lead_d;
        left_q   <= left_d;
      end
      if (cfg_wr) begin
        tick_q <= pwdata;
      end else if (s1_adv) begin
        tick_q <= tick_d;
      end
    end
  end

  // result register
  result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= res_vld;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_vld) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.kind         = out_q.kind;
  assign result_o.chunk_type   = out_q.chunk_type;
  assign result_o.keyframe     = out_q.keyframe;
  assign result_o.tick         = out_q.tick;
  assign result_o.payload_size = out_q.payload_size;
  assign result_o.payload_byte = out_q.payload_byte;
  assign result_o.payload_last = out_q.payload_last;
  assign result_o.truncated    = out_q.truncated;

  // checks
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhasePayload) |-> (left_q != '0))
    else $error("payload phase with no bytes left");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhaseIdle) |-> (extra_q == '0 && left_q == '0))
    else $error("idle phase with pending counts");

  a_end_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.stream_end) |=> (phase_q == PhaseIdle && tick_q == start_q))
    else $error("stream end did not return to idle with reloaded tick");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == KindPayload && out_q.truncated) |-> out_q.payload_last)
    else $error("truncated payload byte without last flag");

endmodule
